### sv/xmrg_pkg.sv
// Shared types and constants of the xorshift-multiply random generator.
package xmrg_pkg;

    // Stream widths: payload fields packed from bit 0, padded to whole bytes
    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 128;

    // Generator constants
    localparam logic [63:0] MIX_MASK   = 64'hEFB3_8A9C_0D39_F73A;
    localparam logic [63:0] MIX_MUL    = 64'd54477213871;
    localparam logic [63:0] STAR_MUL   = 64'h2545_F491_4F6C_DD1D;
    localparam logic [63:0] INIT_ADD   = 64'd993319;
    localparam logic [7:0]  MOD_PERIOD = 8'd100;
    localparam int          XS_SHIFT_A = 12;
    localparam int          XS_SHIFT_B = 25;
    localparam int          XS_SHIFT_C = 27;
    localparam int          INIT_SHIFT = 33;

    // Request kinds carried in the low bits of an input item
    typedef enum logic [1:0] {
        FUNC_DRAW   = 2'd0,
        FUNC_RESEED = 2'd1,
        FUNC_INIT   = 2'd2
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_MIX,
        ST_STAR,
        ST_XS,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### sv/xmrg_mul.sv
// Iterative 64x64 multiplier keeping the low 64 bits, one 16-bit digit per cycle.
module xmrg_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    import xmrg_pkg::*;

    localparam int DIGIT_W = 16;

    logic [63:0]          a_reg, b_reg, acc_reg;
    logic [1:0]           cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIGIT_W+63:0]  partial;

    // One partial product per cycle; the multiplicand moves up one digit
    assign partial = a_reg * b_reg[DIGIT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + partial[63:0];
            a_reg   <= {a_reg[63-DIGIT_W:0], {DIGIT_W{1'b0}}};
            b_reg   <= {{DIGIT_W{1'b0}}, b_reg[63:DIGIT_W]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### sv/xmrg_mod100.sv
// Multiple-of-100 test on a 64-bit word by residue folding.
module xmrg_mod100 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] n,
    output logic        done,
    output logic        is_multiple
);
    import xmrg_pkg::*;

    // 2^20 is 1 and 2^10 is -1 modulo 25; 1025 is a multiple of 25 that keeps the
    // folded difference positive; 5243 / 2^17 sits just above 1/25
    localparam logic [11:0] FOLD_BIAS = 12'd1025;
    localparam logic [12:0] RECIP_25  = 13'd5243;
    localparam logic [11:0] DIV_25    = 12'd25;
    localparam int          RECIP_SH  = 17;

    logic [63:0] n_reg;
    logic [21:0] sum_reg, sum_next;
    logic [19:0] fold_reg, fold_next;
    logic [11:0] t_reg, t_next;
    logic [20:0] fold_part;
    logic [24:0] prod;
    logic [7:0]  quot;
    logic [11:0] rem;
    logic [1:0]  cnt_reg;
    logic        busy_reg, done_reg, multiple_reg;

    // Fold 20-bit chunks, fold again, fold 10-bit halves, then check the small residue
    always_comb begin
        sum_next  = 22'(n_reg[19:0]) + 22'(n_reg[39:20])
                  + 22'(n_reg[59:40]) + 22'(n_reg[63:60]);
        fold_part = 21'(sum_reg[19:0]) + 21'(sum_reg[21:20]);
        fold_next = fold_part[19:0] + 20'(fold_part[20]);
        t_next    = 12'(fold_reg[9:0]) + FOLD_BIAS - 12'(fold_reg[19:10]);
        prod      = 25'(t_reg) * 25'(RECIP_25);
        quot      = prod[24:RECIP_SH];
        rem       = t_reg - 12'(quot) * DIV_25;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the word, advance one folding stage per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= n;
        end else if (busy_reg) begin
            sum_reg      <= sum_next;
            fold_reg     <= fold_next;
            t_reg        <= t_next;
            multiple_reg <= (n_reg[1:0] == 2'd0) && (rem == 12'd0);
        end
    end

    assign done        = done_reg;
    assign is_multiple = multiple_reg;

endmodule

### sv/xmrg_div.sv
// Radix-2 restoring remainder unit for 64-bit words, one bit per cycle.
module xmrg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic        done,
    output logic [63:0] remainder
);
    import xmrg_pkg::*;

    logic [63:0] n_reg, d_reg, rem_reg, rem_next;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {rem_reg, n_reg[63]};
        if (trial >= {1'b0, d_reg}) begin
            trial = trial - {1'b0, d_reg};
        end
        rem_next = trial[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[62:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### sv/xorshift_multiply_random_generator.sv
// Top level: sequencer and seed datapath of the xorshift-multiply random generator.
// Draw: decode, multiple-of-100 test, multiply, xorshift, remainder, output; the remainder
//   step is skipped when the span wraps to zero.
// Accept to next accept: a draw also waits out any output stall; unused codes end at decode.
// One item at a time; s_tready is high only while idle, and the result register lets
//   the next item in while a result waits. Synchronous reset clears seed, drops m_tvalid.
module xorshift_multiply_random_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[1:0], timestamp[65:2], value[129:66], range_start[193:130],
    // range_end[257:194], zero pad[263:258]
    input  logic [xmrg_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // random_word[63:0], ranged_value[127:64]
    output logic [xmrg_pkg::M_TDATA_W-1:0] m_tdata
);
    import xmrg_pkg::*;

    state_t      state_reg, state_next;
    func_t       func_reg;
    logic [63:0] ts_reg, val_reg, start_reg, end_reg;
    logic [63:0] seed_reg, work_reg, ranged_reg;
    logic [63:0] out_word_reg, out_ranged_reg;
    logic        m_tvalid_reg;

    logic        accept, out_free, out_load;
    logic        mul_start, mul_done, mod_start, mod_done, mod_zero, div_start, div_done;
    logic [63:0] mul_a, mul_b, mul_res, div_rem, mix_w, xs_w, span;

    function automatic logic [63:0] xs_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> XS_SHIFT_A);
        t = t ^ (t << XS_SHIFT_B);
        t = t ^ (t >> XS_SHIFT_C);
        return t;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mix_w    = (~seed_reg & MIX_MASK) ^ mul_res;
    assign xs_w     = xs_step(work_reg);
    assign span     = end_reg - start_reg + 64'd1;

    // Shared units
    xmrg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_res)
    );

    xmrg_mod100 u_mod100 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (mod_start),
        .n           (seed_reg),
        .done        (mod_done),
        .is_multiple (mod_zero)
    );

    xmrg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .n         (xs_w),
        .d         (span),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (func_reg)
                    FUNC_DRAW:   state_next = ST_MOD;
                    FUNC_RESEED: state_next = ST_MIX;
                    FUNC_INIT:   state_next = ST_XS;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_MOD: begin
                if (mod_done) state_next = mod_zero ? ST_MIX : ST_STAR;
            end
            ST_MIX: begin
                if (mul_done) state_next = (func_reg == FUNC_DRAW) ? ST_XS : ST_STAR;
            end
            ST_STAR: begin
                if (mul_done) state_next = (func_reg == FUNC_DRAW) ? ST_XS : ST_IDLE;
            end
            ST_XS: begin
                if (func_reg == FUNC_DRAW) begin
                    state_next = (span == 64'd0) ? ST_OUT : ST_DIV;
                end else begin
                    state_next = ST_STAR;
                end
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Unit starts, operand selection, handshake
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = seed_reg;
        mul_b     = STAR_MUL;
        mod_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DECODE: begin
                if (func_reg == FUNC_DRAW) begin
                    mod_start = 1'b1;
                end else if (func_reg == FUNC_RESEED) begin
                    mul_start = 1'b1;
                    mul_a     = val_reg + seed_reg;
                    mul_b     = MIX_MUL;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    mul_start = 1'b1;
                    if (mod_zero) begin
                        mul_a = ts_reg + seed_reg;
                        mul_b = MIX_MUL;
                    end
                end
            end
            ST_MIX: begin
                if (mul_done && func_reg != FUNC_DRAW) begin
                    mul_start = 1'b1;
                    mul_a     = mix_w;
                end
            end
            ST_XS: begin
                if (func_reg == FUNC_DRAW) begin
                    div_start = (span != 64'd0);
                end else begin
                    mul_start = 1'b1;
                    mul_a     = xs_w;
                end
            end
            ST_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seed_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Commit the new seed
            if (state_reg == ST_XS && func_reg == FUNC_DRAW) begin
                seed_reg <= xs_w;
            end else if (state_reg == ST_STAR && mul_done && func_reg != FUNC_DRAW) begin
                seed_reg <= mul_res;
            end
            // Hold the result until taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= func_t'(s_tdata[1:0]);
            ts_reg    <= s_tdata[65:2];
            val_reg   <= s_tdata[129:66];
            start_reg <= s_tdata[193:130];
            end_reg   <= s_tdata[257:194];
        end
        if (state_reg == ST_DECODE && func_reg == FUNC_INIT) begin
            work_reg <= ts_reg + INIT_ADD + (val_reg << INIT_SHIFT);
        end else if (state_reg == ST_MIX && mul_done && func_reg == FUNC_DRAW) begin
            work_reg <= mix_w;
        end else if (state_reg == ST_STAR && mul_done && func_reg == FUNC_DRAW) begin
            work_reg <= mul_res;
        end
        // Full-range draw passes the raw word through
        if (state_reg == ST_XS) begin
            ranged_reg <= xs_w;
        end else if (state_reg == ST_DIV && div_done) begin
            ranged_reg <= div_rem + start_reg;
        end
        if (out_load) begin
            out_word_reg   <= seed_reg;
            out_ranged_reg <= ranged_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_ranged_reg, out_word_reg};

endmodule

### sv/xmrg_checker.sv
// Port-level checker for the random generator, bound to the top level.
module xmrg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [xmrg_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [xmrg_pkg::M_TDATA_W-1:0] m_tdata
);
    import xmrg_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // Accepting an item makes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // A new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item appeared without work");

endmodule

bind xorshift_multiply_random_generator xmrg_checker u_xmrg_checker (.*);

### sim/tb_xorshift_multiply_random_generator.sv
// Self-checking testbench for the xorshift-multiply random generator stream block.
module tb_xorshift_multiply_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import xmrg_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_A         = 64'h5555_5555_5555_5555;
    localparam logic [63:0] HALF_B         = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam int          NUM_DIRECTED   = 23;
    localparam int          NUM_ITEMS      = 1600;
    localparam int          MAX_GAP        = 11;
    localparam int          HOLDOFF_AT     = 200;
    localparam int          HOLDOFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES   = 120;

    typedef struct {
        logic [1:0]  func;
        logic [63:0] stamp;
        logic [63:0] value;
        logic [63:0] lo;
        logic [63:0] hi;
    } request_t;

    typedef struct {
        logic [63:0] word;
        logic [63:0] ranged;
    } draw_t;

    // align: replace value by one that leaves the seed a multiple of 100
    // pin: ranged value known up front
    typedef struct {
        request_t    req;
        bit          align;
        bit          pin;
        logic [63:0] pinned;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Generator state as predicted from accepted items
    logic [63:0] model_seed;
    draw_t       expected_draws[$];

    int  fail_count      = 0;
    int  draws_checked   = 0;
    int  n_draws         = 0;
    int  n_reseeds       = 0;
    int  n_inits         = 0;
    int  n_ignored       = 0;
    int  aligned_draws   = 0;
    int  full_span_draws = 0;
    bit  send_burst      = 0;
    bit  held_off        = 0;

    directed_row_t directed_rows [NUM_DIRECTED];

    xorshift_multiply_random_generator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] mix_seed(input logic [63:0] s, input logic [63:0] v);
        return (~s & MIX_MASK) ^ ((v + s) * MIX_MUL);
    endfunction

    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> XS_SHIFT_A);
        t = t ^ (t << XS_SHIFT_B);
        t = t ^ (t >> XS_SHIFT_C);
        return t;
    endfunction

    // Advance the predicted seed by one item; return 1 when it yields a draw
    function automatic bit advance_seed(input request_t r, output draw_t d);
        logic [63:0] s;
        logic [63:0] span;
        d.word   = '0;
        d.ranged = '0;
        case (r.func)
            FUNC_DRAW: begin
                if (model_seed % MOD_PERIOD == 0) begin
                    s = mix_seed(model_seed, r.stamp);
                    aligned_draws++;
                end else begin
                    s = model_seed * STAR_MUL;
                end
                s          = xorshift_step(s);
                model_seed = s;
                span       = r.hi - r.lo + 64'd1;
                d.word     = s;
                if (span == 0) begin
                    d.ranged = s;
                    full_span_draws++;
                end else begin
                    d.ranged = (s % span) + r.lo;
                end
                return 1'b1;
            end
            FUNC_RESEED: begin
                model_seed = mix_seed(model_seed, r.value) * STAR_MUL;
            end
            FUNC_INIT: begin
                model_seed = xorshift_step(r.stamp + INIT_ADD + (r.value << INIT_SHIFT))
                             * STAR_MUL;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    // Search a reseed value that leaves the seed a multiple of 100
    function automatic logic [63:0] aligning_value();
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 5000; k++) begin
            v = rand64();
            if ((mix_seed(model_seed, v) * STAR_MUL) % MOD_PERIOD == 0) return v;
        end
        return v;
    endfunction

    // Build one random item; mostly draws with varied ranges
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       shape;
        r.func  = FUNC_DRAW;
        r.stamp = rand64();
        r.value = rand64();
        r.lo    = rand64();
        r.hi    = rand64();
        pick    = $urandom_range(0, 99);
        if (pick < 60) begin
            shape = $urandom_range(0, 9);
            case (shape)
                0: begin
                    r.lo = '0;
                    r.hi = ALL_ONES;
                end
                1: r.hi = r.lo - 64'd1;
                2: r.hi = r.lo;
                3, 4, 5: r.hi = r.lo + 64'($urandom_range(1, 1000));
                6: begin
                    r.hi = r.lo - 64'($urandom_range(2, 1000));
                end
                default: begin
                end
            endcase
        end else if (pick < 72) begin
            r.func = FUNC_RESEED;
        end else if (pick < 80) begin
            r.func = FUNC_INIT;
        end else if (pick < 85) begin
            r.func = FUNC_UNUSED;
        end else begin
            r.func  = FUNC_RESEED;
            r.value = aligning_value();
        end
        return r;
    endfunction

    // Offer one item after a random gap, or none during a burst, then predict it once accepted
    task automatic send_request(input request_t r, input bit pin, input logic [63:0] pinned);
        int    gap;
        draw_t d;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.hi, r.lo, r.value, r.stamp, r.func};
        do @(posedge aclk); while (!s_tready);
        if (advance_seed(r, d)) begin
            if (pin) d.ranged = pinned;
            expected_draws.push_back(d);
        end
        case (r.func)
            FUNC_DRAW:   n_draws++;
            FUNC_RESEED: n_reseeds++;
            FUNC_INIT:   n_inits++;
            default:     n_ignored++;
        endcase
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        draw_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected result word %h ranged %h",
                         $time, m_tdata[63:0], m_tdata[127:64]);
                fail_count++;
            end else begin
                want = expected_draws.pop_front();
                if (m_tdata[63:0] !== want.word) begin
                    $display("%0t: random_word expected %h got %h",
                             $time, want.word, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[127:64] !== want.ranged) begin
                    $display("%0t: ranged_value expected %h got %h",
                             $time, want.ranged, m_tdata[127:64]);
                    fail_count++;
                end
                draws_checked++;
            end
        end
    end

    // Receiver: random stalls, bursts without stalls, one long hold-off
    initial begin : drive_ready
        int stall;
        int n;
        bit burst;
        n        = 0;
        burst    = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (!held_off && draws_checked >= HOLDOFF_AT) begin
                stall    = HOLDOFF_CYCLES;
                held_off = 1'b1;
            end else begin
                stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n++;
        end
    end

    // Stop a hung run
    initial begin : watchdog
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        request_t r;
        int       counted;
        int       sent;
        // Seed zero after reset takes the timestamp mix path on the first draw
        directed_rows = '{
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd5,    64'd5},    1'b0, 1'b1, 64'd5},
            '{'{FUNC_DRAW,   ALL_ONES, 64'd0,    64'd0,    ALL_ONES}, 1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd7,    64'd0,    ALL_ONES, ALL_ONES}, 1'b0, 1'b1, ALL_ONES},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd0,    64'd0},    1'b0, 1'b1, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'hFFFF_0000_0000_0000, 64'h10},
              1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd1,    64'd0},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_RESEED, 64'd0,    64'd0,    64'd0,    64'd0},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd0,    64'd99},   1'b0, 1'b0, 64'd0},
            '{'{FUNC_RESEED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd100,  64'd199},  1'b0, 1'b0, 64'd0},
            '{'{FUNC_INIT,   64'd0,    64'd0,    64'd0,    64'd0},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    64'd0,    ALL_ONES - 64'd1},
              1'b0, 1'b0, 64'd0},
            '{'{FUNC_INIT,   ALL_ONES, ALL_ONES, 64'd0,    64'd0},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   64'd0,    64'd0,    ALL_ONES - 64'd9, ALL_ONES},
              1'b0, 1'b0, 64'd0},
            '{'{FUNC_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   ALL_ONES, 64'd0,    64'd0,    64'd1},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_UNUSED, 64'd0,    64'd0,    64'd0,    64'd0},    1'b0, 1'b0, 64'd0},
            '{'{FUNC_RESEED, 64'd0,    64'd0,    64'd0,    64'd0},    1'b1, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   ALL_ONES, 64'd0,    64'h8000_0000_0000_0000,
                64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, 1'b0, 64'd0},
            '{'{FUNC_RESEED, 64'd0,    64'd0,    64'd0,    64'd0},    1'b1, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   HALF_A,   HALF_B,   HALF_A,   HALF_B},   1'b0, 1'b0, 64'd0},
            '{'{FUNC_INIT,   HALF_A,   HALF_B,   HALF_B,   HALF_A},   1'b0, 1'b0, 64'd0},
            '{'{FUNC_DRAW,   HALF_B,   HALF_A,   HALF_B,   HALF_A},   1'b0, 1'b0, 64'd0}
        };
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        model_seed = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed rows
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            r = directed_rows[i].req;
            if (directed_rows[i].align) r.value = aligning_value();
            send_request(r, directed_rows[i].pin, directed_rows[i].pinned);
        end

        // Random items; ignored codes do not count toward the total
        counted = 0;
        sent    = 0;
        while (counted < NUM_ITEMS) begin
            if (sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
            r = random_request();
            send_request(r, 1'b0, 64'd0);
            if (r.func != FUNC_UNUSED) counted++;
            sent++;
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain, then let the last no-result item settle
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d draws (%0d checked), %0d reseeds, %0d inits, %0d ignored codes",
                 n_draws, draws_checked, n_reseeds, n_inits, n_ignored);
        $display("Seed was a multiple of 100 for %0d draws; %0d draws asked the full range",
                 aligned_draws, full_span_draws);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
